[rtl/smx_pkg.sv]
package smx_pkg;

    localparam int OP_W   = 8;
    localparam int WORD_W = 32;
    localparam int ERR_W  = 3;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 3'd0,
        ERR_DIVZERO = 3'd1,
        ERR_GLOBAL  = 3'd2,
        ERR_OPCODE  = 3'd3,
        ERR_UNDER   = 3'd4,
        ERR_OVER    = 3'd5
    } err_t;

    localparam logic [OP_W-1:0] OP_HALT  = 8'd0;
    localparam logic [OP_W-1:0] OP_PUSHC = 8'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 8'd2;
    localparam logic [OP_W-1:0] OP_SUB   = 8'd3;
    localparam logic [OP_W-1:0] OP_MUL   = 8'd4;
    localparam logic [OP_W-1:0] OP_DIV   = 8'd5;
    localparam logic [OP_W-1:0] OP_MOD   = 8'd6;
    localparam logic [OP_W-1:0] OP_RDINT = 8'd7;
    localparam logic [OP_W-1:0] OP_WRINT = 8'd8;
    localparam logic [OP_W-1:0] OP_RDCHR = 8'd9;
    localparam logic [OP_W-1:0] OP_WRCHR = 8'd10;
    localparam logic [OP_W-1:0] OP_PUSHG = 8'd11;
    localparam logic [OP_W-1:0] OP_POPG  = 8'd12;
    localparam logic [OP_W-1:0] OP_FRM0  = 8'd13;
    localparam logic [OP_W-1:0] OP_FRM3  = 8'd16;

    localparam logic [1:0] REG_GLOBAL_COUNT = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_CLEAR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic              is_mod;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } div_rsp_t;

endpackage

[rtl/smx_divider.sv]
module smx_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  smx_pkg::div_req_t req,
    output smx_pkg::div_rsp_t rsp
);
    import smx_pkg::*;

    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic              mod_reg, mod_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        negq_next = negq_reg;
        negr_next = negr_reg;
        mod_next  = mod_reg;
        shifted   = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
        trial     = {1'b0, shifted} - {1'b0, den_reg};
        if (req.start)
        begin
            quo_next  = req.a[WORD_W-1] ? (~req.a + 1'b1) : req.a;
            den_next  = req.b[WORD_W-1] ? (~req.b + 1'b1) : req.b;
            rem_next  = '0;
            cnt_next  = 6'(WORD_W);
            busy_next = 1'b1;
            negq_next = req.a[WORD_W-1] ^ req.b[WORD_W-1];
            negr_next = req.a[WORD_W-1];
            mod_next  = req.is_mod;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                // rem is a pure remainder, top bit of shifted cannot drop
                if (rem_reg[WORD_W-1] == 1'b0 && !trial[WORD_W])
                begin
                    rem_next = trial[WORD_W-1:0];
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end
                else if (rem_reg[WORD_W-1])
                begin
                    rem_next = shifted - den_reg;
                    quo_next = {quo_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[WORD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        mod_reg  <= mod_next;
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (mod_reg)
            rsp.result = negr_reg ? (~rem_reg + 1'b1) : rem_reg;
        else
            rsp.result = negq_reg ? (~quo_reg + 1'b1) : quo_reg;
    end

endmodule

[rtl/stack_machine_execute_unit.sv]
// Stack machine execute unit.
// s_axis carries one instruction word per item: tdata holds instruction
// (bits 31:0) and read_value (bits 63:32). m_axis returns one result word per
// instruction: tdata holds write_value (31:0), error_code (34:32), zero
// padding above; tuser holds write_valid (0), write_is_char (1), halted (2).
// global_count is written over APB at address 0.
// One instruction is taken at a time. Stack operations read the stack
// memory in ST_READ, execute and write back in ST_EXEC, and present the
// result in ST_OUT, where m_axis_tvalid is high. pushg repeats the read
// state. div and mod run a radix-2 divider in ST_DIV, which writes the
// result back.
// After reset the global store is cleared one entry per cycle, all
// GLOBAL_DEPTH entries, during which s_axis_tready is low.
// The result word waits in an output register while m_axis_tready is low;
// no new instruction is taken until it has been delivered.
// Once halted, instructions are still accepted and answered with the latched
// halted and error_code, and they change nothing.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH  = 256,
    parameter int GLOBAL_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // instruction, read_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // write_value, error_code
    output logic [2:0]  m_axis_tuser,  // write_valid, write_is_char, halted
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smx_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int GAW = (GLOBAL_DEPTH > 1) ? $clog2(GLOBAL_DEPTH) : 1;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] glob_mem  [GLOBAL_DEPTH];

    state_t state_reg, state_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic              halt_reg, halt_next;
    logic [ERR_W-1:0]  err_reg, err_next;
    logic [6:0]        gcount_reg;
    logic [GAW:0]      clr_reg, clr_next;
    logic [WORD_W-1:0] inst_reg, rdv_reg;
    logic              stage_reg, stage_next;
    logic [WORD_W-1:0] a_reg, b_reg, g_reg;
    logic [WORD_W-1:0] wval_reg, wval_next;
    logic              wvalid_reg, wvalid_next, wchar_reg, wchar_next;

    logic [OP_W-1:0]   opcode;
    logic [WORD_W-1:0] imm;
    logic              glob_ok;
    logic [SAW-1:0]    rd_addr_a, rd_addr_b;
    logic              st_we;
    logic [SAW-1:0]    st_waddr;
    logic [WORD_W-1:0] st_wdata;
    logic              gl_we;
    logic [GAW-1:0]    gl_waddr;
    logic [WORD_W-1:0] gl_wdata;
    logic              cfg_we;
    div_req_t          dreq;
    div_rsp_t          drsp;

    assign opcode = inst_reg[31:24];
    assign imm    = {{8{inst_reg[23]}}, inst_reg[23:0]};
    assign glob_ok = !imm[WORD_W-1] && (imm < WORD_W'(gcount_reg))
                     && (imm < WORD_W'(GLOBAL_DEPTH));
    assign rd_addr_a = SAW'(sp_reg - SPW'(2));
    assign rd_addr_b = SAW'(sp_reg - SPW'(1));

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_GLOBAL_COUNT);
    assign prdata = (paddr == REG_GLOBAL_COUNT) ? {25'd0, gcount_reg} : '0;

    smx_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (GAW+1)'(GLOBAL_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_READ;
            ST_READ:
            begin
                if (opcode inside {OP_PUSHG} && !stage_reg) state_next = ST_READ;
                else state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!halt_reg && (opcode == OP_DIV || opcode == OP_MOD)
                    && sp_reg >= SPW'(2) && b_reg != '0)
                    state_next = ST_DIV;
                else
                    state_next = ST_OUT;
            end
            ST_DIV:   if (drsp.done) state_next = ST_OUT;
            ST_OUT:   if (m_axis_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sp_next     = sp_reg;
        halt_next   = halt_reg;
        err_next    = err_reg;
        clr_next    = clr_reg;
        stage_next  = 1'b0;
        wval_next   = wval_reg;
        wvalid_next = wvalid_reg;
        wchar_next  = wchar_reg;
        st_we       = 1'b0;
        st_waddr    = SAW'(sp_reg);
        st_wdata    = '0;
        gl_we       = 1'b0;
        gl_waddr    = GAW'(imm);
        gl_wdata    = b_reg;
        dreq.start  = 1'b0;
        dreq.is_mod = (opcode == OP_MOD);
        dreq.a      = a_reg;
        dreq.b      = b_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                gl_we    = 1'b1;
                gl_waddr = GAW'(clr_reg);
                gl_wdata = '0;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                wvalid_next = 1'b0;
                wchar_next  = 1'b0;
                wval_next   = '0;
            end
            ST_READ:  stage_next = 1'b1;
            ST_EXEC:
            begin
                if (!halt_reg)
                begin
                    case (opcode)
                        OP_HALT: halt_next = 1'b1;
                        OP_PUSHC, OP_RDINT, OP_RDCHR, OP_PUSHG:
                        begin
                            if (opcode == OP_PUSHG && !glob_ok)
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_GLOBAL;
                            end
                            else if (sp_reg >= SPW'(STACK_DEPTH))
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_OVER;
                            end
                            else
                            begin
                                st_we = 1'b1;
                                if (opcode == OP_PUSHC) st_wdata = imm;
                                else if (opcode == OP_RDINT) st_wdata = rdv_reg;
                                else if (opcode == OP_RDCHR)
                                    st_wdata = {{24{rdv_reg[7]}}, rdv_reg[7:0]};
                                else st_wdata = g_reg;
                                sp_next = sp_reg + 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                        begin
                            if (sp_reg < SPW'(2))
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_UNDER;
                            end
                            else if ((opcode == OP_DIV || opcode == OP_MOD)
                                     && b_reg == '0)
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_DIVZERO;
                            end
                            else if (opcode == OP_DIV || opcode == OP_MOD)
                                dreq.start = 1'b1;
                            else
                            begin
                                st_we    = 1'b1;
                                st_waddr = rd_addr_a;
                                if (opcode == OP_ADD) st_wdata = a_reg + b_reg;
                                else if (opcode == OP_SUB) st_wdata = a_reg - b_reg;
                                else st_wdata = a_reg * b_reg;
                                sp_next = sp_reg - 1'b1;
                            end
                        end
                        OP_WRINT, OP_WRCHR, OP_POPG:
                        begin
                            if (opcode == OP_POPG && !glob_ok)
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_GLOBAL;
                            end
                            else if (sp_reg < SPW'(1))
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_UNDER;
                            end
                            else
                            begin
                                if (opcode == OP_POPG) gl_we = 1'b1;
                                else
                                begin
                                    wvalid_next = 1'b1;
                                    wval_next   = b_reg;
                                    wchar_next  = (opcode == OP_WRCHR);
                                end
                                sp_next = sp_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!(opcode inside {[OP_FRM0:OP_FRM3]}))
                            begin
                                halt_next = 1'b1;
                                err_next  = ERR_OPCODE;
                            end
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    st_we    = 1'b1;
                    st_waddr = rd_addr_a;
                    st_wdata = drsp.result;
                    sp_next  = sp_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            sp_reg     <= '0;
            halt_reg   <= 1'b0;
            err_reg    <= ERR_NONE;
            gcount_reg <= '0;
            clr_reg    <= '0;
            stage_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            halt_reg  <= halt_next;
            err_reg   <= err_next;
            clr_reg   <= clr_next;
            stage_reg <= stage_next;
            if (cfg_we) gcount_reg <= pwdata[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_axis_tvalid)
        begin
            inst_reg <= s_axis_tdata[31:0];
            rdv_reg  <= s_axis_tdata[63:32];
        end
        wval_reg   <= wval_next;
        wvalid_reg <= wvalid_next;
        wchar_reg  <= wchar_next;
        if (state_reg == ST_READ)
        begin
            a_reg <= stack_mem[rd_addr_a];
            b_reg <= stack_mem[rd_addr_b];
            g_reg <= glob_mem[GAW'(imm)];
        end
        if (st_we) stack_mem[st_waddr] <= st_wdata;
        if (gl_we) glob_mem[gl_waddr] <= gl_wdata;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {5'd0, err_reg, wval_reg};
    assign m_axis_tuser  = {halt_reg, wchar_reg, wvalid_reg};

endmodule

[rtl/smx_checker.sv]
module smx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    import smx_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(s_axis_tvalid && s_axis_tready))
        else $error("input taken while result pending");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[2] |=>
        !m_axis_tvalid || m_axis_tuser[2])
        else $error("halt latch cleared");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[34:32] != ERR_NONE |-> m_axis_tuser[2])
        else $error("error without halt");

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
